>>> rtl/core/fpsr_pkg.sv
// Shared types and constants for the fixed-point scaler with remainder carry.
package fpsr_pkg;

  localparam int DATA_W      = 32;
  localparam int PROD_W      = 64;
  localparam int BASE_SHIFT  = 11;
  localparam int QUEUE_DEPTH = 2;

  // One classified word on its way from the front to the back.
  typedef struct packed {
    logic [PROD_W-1:0] product;
    logic [DATA_W-1:0] scale;
    logic              axis;
    logic              bypass;
  } entry_t;

endpackage

>>> rtl/core/fpsr_front.sv
// Front stage: accepts input words, forms the product and flags uncorrected scales.
module fpsr_front #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        valid,
  output logic                        stall,
  input  logic [fpsr_pkg::DATA_W-1:0] delta,
  input  logic [fpsr_pkg::DATA_W-1:0] scale,
  input  logic                        axis_select,
  input  logic [fpsr_pkg::DATA_W-1:0] base_scale_word,
  output logic                        push,
  input  logic                        push_ready,
  output fpsr_pkg::entry_t            entry
);

  localparam int PW = fpsr_pkg::PROD_W;

  logic                               held;
  logic signed [fpsr_pkg::PROD_W-1:0] product;
  logic [fpsr_pkg::DATA_W-1:0]        base_scaled;
  logic                               bypass;

  assign base_scaled = {base_scale_word[fpsr_pkg::DATA_W-1-fpsr_pkg::BASE_SHIFT:0],
                        {fpsr_pkg::BASE_SHIFT{1'b0}}};
  assign product     = PW'($signed(delta)) * PW'($signed(scale));
  assign bypass      = (scale == base_scaled) || (scale[FRACTION_BITS-1:0] == '0);

  assign push  = held;
  assign stall = held && !push_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (!stall) begin
      held <= valid;
    end
  end

  always_ff @(posedge clk) begin
    if (valid && !stall) begin
      entry.product <= product;
      entry.scale   <= scale;
      entry.axis    <= axis_select;
      entry.bypass  <= bypass;
    end
  end

endmodule

>>> rtl/core/fpsr_queue.sv
// Two-entry queue between the front and back stages.
module fpsr_queue (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  output logic             push_ready,
  input  fpsr_pkg::entry_t push_entry,
  output logic             pop_valid,
  input  logic             pop,
  output fpsr_pkg::entry_t pop_entry
);

  localparam int PTR_W = $clog2(fpsr_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(fpsr_pkg::QUEUE_DEPTH + 1);

  fpsr_pkg::entry_t slots [fpsr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;
  logic             full;

  assign full       = (count == CNT_W'(fpsr_pkg::QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign do_pop     = pop && pop_valid;
  // a full queue still takes a word in the cycle it drops one
  assign push_ready = !full || do_pop;
  assign do_push    = push && push_ready;
  assign pop_entry  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(fpsr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(fpsr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

endmodule

>>> rtl/core/fpsr_back.sv
// Back stage: remainder carry, truncating divide and the output register.
module fpsr_back #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        pop_valid,
  output logic                        pop,
  input  fpsr_pkg::entry_t            pop_entry,
  output logic                        scaled_valid,
  input  logic                        scaled_stall,
  output logic [fpsr_pkg::DATA_W-1:0] scaled_delta
);

  localparam int PW = fpsr_pkg::PROD_W;
  localparam int DW = fpsr_pkg::DATA_W;

  logic [PW-1:0] remainder [2];
  logic [DW-1:0] tracked_scale;
  logic          tracking_active;

  logic          take;
  logic          change;
  logic [PW-1:0] rem_sel;
  logic [PW-1:0] sum;
  logic [PW-1:0] floor_q;
  logic          round_up;
  logic [DW-1:0] q;
  logic [PW-1:0] rem_next;
  logic [DW-1:0] result;

  assign pop  = !scaled_valid || !scaled_stall;
  assign take = pop && pop_valid;

  always_comb begin
    change   = !tracking_active || (tracked_scale != pop_entry.scale);
    rem_sel  = change ? '0 : remainder[pop_entry.axis];
    sum      = pop_entry.product + rem_sel;
    floor_q  = PW'($signed(sum) >>> FRACTION_BITS);
    // truncate toward zero: negative sums with a fraction round up
    round_up = sum[PW-1] && (sum[FRACTION_BITS-1:0] != '0);
    q        = floor_q[DW-1:0] + DW'(round_up);
    rem_next = sum - ({{(PW-DW){q[DW-1]}}, q} << FRACTION_BITS);
    if (pop_entry.bypass) begin
      result = pop_entry.product[DW-1+FRACTION_BITS:FRACTION_BITS];
    end else begin
      result = q;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scaled_valid    <= 1'b0;
      remainder[0]    <= '0;
      remainder[1]    <= '0;
      tracked_scale   <= '0;
      tracking_active <= 1'b0;
    end else begin
      if (pop) begin
        scaled_valid <= pop_valid;
      end
      if (take) begin
        if (pop_entry.bypass) begin
          remainder[0]    <= '0;
          remainder[1]    <= '0;
          tracked_scale   <= '0;
          tracking_active <= 1'b0;
        end else begin
          tracked_scale   <= pop_entry.scale;
          tracking_active <= 1'b1;
          remainder[pop_entry.axis] <= rem_next;
          if (change) begin
            remainder[!pop_entry.axis] <= '0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      scaled_delta <= result;
    end
  end

endmodule

>>> rtl/core/fixed_point_scale_with_remainder_core.sv
// Fixed-point motion scaler with per-axis remainder carry, top level.
// A result word passes the front register, a queue slot and the output register.
// Throughput: one word per cycle while scaled_stall is low; the per-axis remainder
// add and divide in the back stage closes its loop through the remainder registers.
// Reset (synchronous, active high) clears remainders, scale tracking, the base
// scale word, the queue and both valid flags.
module fixed_point_scale_with_remainder_core #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        base_scale_word_we,
  input  logic [fpsr_pkg::DATA_W-1:0] base_scale_word,
  input  logic                        valid,
  output logic                        stall,
  input  logic [fpsr_pkg::DATA_W-1:0] delta,
  input  logic [fpsr_pkg::DATA_W-1:0] scale,
  input  logic                        axis_select,
  output logic                        scaled_valid,
  input  logic                        scaled_stall,
  output logic [fpsr_pkg::DATA_W-1:0] scaled_delta
);

  logic [fpsr_pkg::DATA_W-1:0] base_reg;
  logic                        push;
  logic                        push_ready;
  fpsr_pkg::entry_t            push_entry;
  logic                        pop_valid;
  logic                        pop;
  fpsr_pkg::entry_t            pop_entry;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_reg <= '0;
    end else if (base_scale_word_we) begin
      base_reg <= base_scale_word;
    end
  end

  fpsr_front #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .valid          (valid),
    .stall          (stall),
    .delta          (delta),
    .scale          (scale),
    .axis_select    (axis_select),
    .base_scale_word(base_reg),
    .push           (push),
    .push_ready     (push_ready),
    .entry          (push_entry)
  );

  fpsr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_ready(push_ready),
    .push_entry(push_entry),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_entry (pop_entry)
  );

  fpsr_back #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .pop_valid   (pop_valid),
    .pop         (pop),
    .pop_entry   (pop_entry),
    .scaled_valid(scaled_valid),
    .scaled_stall(scaled_stall),
    .scaled_delta(scaled_delta)
  );

endmodule

>>> verif/fpsr_scale_checker.sv
// Checker for the fixed-point scaler: predicts each scaled word and compares it.
module fpsr_scale_checker #(
  parameter int FRACTION_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_we,
  input  logic [fpsr_pkg::DATA_W-1:0] cfg_word,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic [fpsr_pkg::DATA_W-1:0] in_delta,
  input  logic [fpsr_pkg::DATA_W-1:0] in_scale,
  input  logic                        in_axis,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic [fpsr_pkg::DATA_W-1:0] out_delta,
  output int                          mismatch_count,
  output int                          pending_words,
  output int                          checked_words
);

  localparam int DATA_W     = fpsr_pkg::DATA_W;
  localparam int PROD_W     = fpsr_pkg::PROD_W;
  localparam int BASE_SHIFT = fpsr_pkg::BASE_SHIFT;

  logic [DATA_W-1:0] base_word;
  logic [DATA_W-1:0] held_scale;
  logic [PROD_W-1:0] carry_rem [2];
  logic              tracking;
  logic [DATA_W-1:0] scaled_q [$];

  function automatic void clear_track();
    carry_rem[0] = '0;
    carry_rem[1] = '0;
    held_scale   = '0;
    tracking     = 1'b0;
  endfunction

  function automatic logic [DATA_W-1:0] scale_delta(input logic [DATA_W-1:0] d,
                                                    input logic [DATA_W-1:0] s,
                                                    input logic              ax);
    logic [PROD_W-1:0] prod;
    logic [PROD_W-1:0] sum;
    logic [PROD_W-1:0] quo;
    logic [DATA_W-1:0] res;
    prod = {{DATA_W{d[DATA_W-1]}}, d} * {{DATA_W{s[DATA_W-1]}}, s};
    // Plain scale or whole-number scale: no carry, drop all tracking.
    if (s == (base_word << BASE_SHIFT) || s[FRACTION_BITS-1:0] == '0) begin
      clear_track();
      quo = prod >> FRACTION_BITS;
      return quo[DATA_W-1:0];
    end
    if (!tracking || held_scale != s) begin
      carry_rem[0] = '0;
      carry_rem[1] = '0;
      held_scale   = s;
      tracking     = 1'b1;
    end
    sum = prod + carry_rem[ax];
    // Truncate toward zero.
    if (sum[PROD_W-1]) quo = -((-sum) >> FRACTION_BITS);
    else quo = sum >> FRACTION_BITS;
    res = quo[DATA_W-1:0];
    carry_rem[ax] = sum - ({{DATA_W{res[DATA_W-1]}}, res} << FRACTION_BITS);
    return res;
  endfunction

  always @(posedge clk) begin
    logic [DATA_W-1:0] want;
    if (rst) begin
      base_word = '0;
      clear_track();
      scaled_q.delete();
      mismatch_count = 0;
      checked_words  = 0;
      pending_words  = 0;
    end else begin
      if (cfg_we) base_word = cfg_word;
      if (out_valid && !out_stall) begin
        if (scaled_q.size() == 0) begin
          mismatch_count++;
          $error("scaled_delta: expected no word, got %0d", $signed(out_delta));
        end else begin
          want = scaled_q.pop_front();
          checked_words++;
          if (out_delta !== want) begin
            mismatch_count++;
            $error("scaled_delta: expected %0d, got %0d", $signed(want),
                   $signed(out_delta));
          end
        end
      end
      if (in_valid && !in_stall) scaled_q.push_back(scale_delta(in_delta, in_scale, in_axis));
      pending_words = scaled_q.size();
    end
  end

endmodule

>>> verif/fixed_point_scale_with_remainder_core_tb.sv
// Testbench top for the fixed-point scaler: stimulus, stalls and verdict.
module fixed_point_scale_with_remainder_core_tb;

  localparam int   DATA_W        = fpsr_pkg::DATA_W;
  localparam int   BASE_SHIFT    = fpsr_pkg::BASE_SHIFT;
  localparam int   FRACTION_BITS = 16;
  localparam logic AXIS_H        = 1'b0;
  localparam logic AXIS_V        = 1'b1;
  localparam int   MAX_WAIT      = 12;
  localparam int   PIPE_LAT      = 2;
  localparam int   RAND_PHASES   = 5;
  localparam int   PHASE_WORDS   = 250;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              base_scale_word_we = 1'b0;
  logic [DATA_W-1:0] base_scale_word = '0;
  logic              valid = 1'b0;
  logic              stall;
  logic [DATA_W-1:0] delta = '0;
  logic [DATA_W-1:0] scale = '0;
  logic              axis_select = AXIS_H;
  logic              scaled_valid;
  logic              scaled_stall = 1'b0;
  logic [DATA_W-1:0] scaled_delta;

  int                mismatch_count;
  int                pending_words;
  int                checked_words;
  int                sent_words = 0;
  int                base_writes = 0;
  int                hold_cnt = 0;
  bit                tx_calm = 1'b0;
  bit                rx_calm = 1'b0;
  logic [DATA_W-1:0] cur_base = '0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  fixed_point_scale_with_remainder_core #(
    .FRACTION_BITS(FRACTION_BITS)
  ) dut (
    .clk(clk),
    .rst(rst),
    .base_scale_word_we(base_scale_word_we),
    .base_scale_word(base_scale_word),
    .valid(valid),
    .stall(stall),
    .delta(delta),
    .scale(scale),
    .axis_select(axis_select),
    .scaled_valid(scaled_valid),
    .scaled_stall(scaled_stall),
    .scaled_delta(scaled_delta)
  );

  fpsr_scale_checker #(
    .FRACTION_BITS(FRACTION_BITS)
  ) u_scale_check (
    .clk(clk),
    .rst(rst),
    .cfg_we(base_scale_word_we),
    .cfg_word(base_scale_word),
    .in_valid(valid),
    .in_stall(stall),
    .in_delta(delta),
    .in_scale(scale),
    .in_axis(axis_select),
    .out_valid(scaled_valid),
    .out_stall(scaled_stall),
    .out_delta(scaled_delta),
    .mismatch_count(mismatch_count),
    .pending_words(pending_words),
    .checked_words(checked_words)
  );

  // Result side: hold stall for a drawn number of cycles after each word,
  // and now and then while idle.
  always @(posedge clk) begin
    if (scaled_valid && !scaled_stall) begin
      hold_cnt = rx_calm ? 0 : $urandom_range(0, MAX_WAIT);
    end else if (hold_cnt != 0) begin
      hold_cnt--;
    end else if (!rx_calm && $urandom_range(0, 7) == 0) begin
      hold_cnt = $urandom_range(1, MAX_WAIT);
    end
    scaled_stall <= (hold_cnt != 0);
  end

  task automatic send_word(input logic [DATA_W-1:0] d_word, input logic [DATA_W-1:0] s_word,
                           input logic ax);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap != 0) begin
      valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    valid       <= 1'b1;
    delta       <= d_word;
    scale       <= s_word;
    axis_select <= ax;
    do @(posedge clk); while (stall);
    sent_words++;
  endtask

  // Hold off until every expected word is back, then let the pipe settle.
  task automatic drain();
    valid <= 1'b0;
    do @(negedge clk); while (pending_words != 0);
    repeat (PIPE_LAT + 1) @(posedge clk);
  endtask

  task automatic write_base(input logic [DATA_W-1:0] w);
    base_scale_word_we <= 1'b1;
    base_scale_word    <= w;
    @(posedge clk);
    base_scale_word_we <= 1'b0;
    cur_base = w;
    base_writes++;
  endtask

  initial begin
    logic [DATA_W-1:0] plain;
    logic [DATA_W-1:0] run_scale;
    logic [DATA_W-1:0] d_word;
    logic [DATA_W-1:0] s_word;
    int                pick;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Plain scale with fraction bits set: 5 << 11 = 0x2800.
    write_base(32'd5);
    send_word(32'd100, 32'h0000_2800, AXIS_H);
    // 1.5 scale: remainders build up and carry, both signs.
    send_word(32'd7, 32'h0001_8000, AXIS_H);
    send_word(32'd7, 32'h0001_8000, AXIS_H);
    send_word(-32'sd7, 32'h0001_8000, AXIS_V);
    send_word(-32'sd7, 32'h0001_8000, AXIS_V);
    // Whole-number scale clears state, then tracking restarts.
    send_word(32'd3, 32'h0002_0000, AXIS_H);
    send_word(32'd7, 32'h0001_8000, AXIS_H);
    // Scale change drops both remainders.
    send_word(32'd5, 32'h0000_4000, AXIS_H);
    // Extremes and quotient overflow.
    send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, AXIS_V);
    send_word(32'h8000_0000, 32'h7FFF_FFFF, AXIS_V);
    send_word(32'h8000_0000, 32'h8000_0000, AXIS_H);
    send_word(32'h8000_0000, 32'h8000_0001, AXIS_H);
    send_word(32'h7FFF_FFFF, 32'h8000_0001, AXIS_V);
    send_word(32'hFFFF_FFFF, 32'hFFFF_FFFF, AXIS_H);
    send_word(32'h0000_0000, 32'hFFFF_FFFF, AXIS_V);
    send_word(32'd123, 32'h0000_0000, AXIS_V);
    // Smallest scale: the carry has to gather many steps.
    repeat (4) send_word(32'd1, 32'h0000_0001, AXIS_H);
    drain();
    write_base(32'h7FFF_FFFF);
    send_word(32'd1000, 32'hFFFF_F800, AXIS_H);
    send_word(-32'sd1000, 32'hFFFF_F800, AXIS_V);
    drain();
    write_base(32'h8000_0000);
    send_word(-32'sd3, 32'h0001_0001, AXIS_V);
    send_word(-32'sd3, 32'h0001_0001, AXIS_V);

    for (int p = 0; p < RAND_PHASES; p++) begin
      drain();
      case (p)
        0:       write_base($urandom);
        1:       write_base(32'hFFFF_FFFF);
        2:       write_base(32'h8000_0000);
        3:       write_base(32'h7FFF_FFFF);
        default: write_base(32'h0000_0000);
      endcase
      tx_calm   = (p == 2);
      rx_calm   = (p == 2) || (p == 4);
      plain     = cur_base << BASE_SHIFT;
      run_scale = $urandom | 32'h1;
      for (int i = 0; i < PHASE_WORDS; i++) begin
        if (p == 1 && i == PHASE_WORDS / 2) drain();
        // Mostly runs on one fractional scale so the carry gets exercised.
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          run_scale = $urandom;
          if (run_scale[FRACTION_BITS-1:0] == '0) run_scale[0] = 1'b1;
          if ($urandom_range(0, 1) != 0)
            run_scale = {{(DATA_W-18){run_scale[17]}}, run_scale[17:0]};
          s_word = run_scale;
        end else if (pick < 75) begin
          s_word = run_scale;
        end else if (pick < 83) begin
          s_word = plain;
        end else if (pick < 91) begin
          s_word = $urandom & 32'hFFFF_0000;
        end else begin
          s_word = $urandom;
        end
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          d_word = $urandom_range(0, 400) - 200;
        end else if (pick < 85) begin
          d_word = $urandom;
        end else begin
          case ($urandom_range(0, 4))
            0:       d_word = 32'h8000_0000;
            1:       d_word = 32'h7FFF_FFFF;
            2:       d_word = 32'h0000_0000;
            3:       d_word = 32'hFFFF_FFFF;
            default: d_word = 32'h0000_0001;
          endcase
        end
        send_word(d_word, s_word, $urandom_range(0, 1) != 0);
      end
    end

    drain();
    repeat (PIPE_LAT + 4) @(posedge clk);
    $display("Scaled %0d deltas under %0d base scale settings; %0d results compared.",
             sent_words, base_writes, checked_words);
    if (mismatch_count == 0 && pending_words == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Verification failed");
    $finish;
  end

endmodule

>>> fixed_point_scale_with_remainder_core.f
rtl/core/fpsr_pkg.sv
rtl/core/fpsr_front.sv
rtl/core/fpsr_queue.sv
rtl/core/fpsr_back.sv
rtl/core/fixed_point_scale_with_remainder_core.sv
verif/fpsr_scale_checker.sv
verif/fixed_point_scale_with_remainder_core_tb.sv
